@@ hdl/tln_pkg.sv @@
// Package with constants, types and helper functions of the text line numberer.
`default_nettype none

package tln_pkg;

   // Number of decimal digits in the line number field.
   localparam int DIGITS = 6;
   localparam int NUM_W  = 4 * DIGITS;

   // Output step counter: DIGITS digit bytes, the tab, then the passed byte.
   localparam int STEPS  = DIGITS + 2;
   localparam int STEP_W = $clog2(STEPS);

   // Decoupling queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0] TAB_BYTE     = 8'h09;
   localparam logic [7:0] SPACE_BYTE   = 8'h20;
   localparam logic [3:0] DIGIT_HIGH   = 4'h3;

   localparam logic [NUM_W-1:0] NUMBER_ONE = NUM_W'(1);

   typedef struct packed {
      logic [7:0]       in_byte;
      logic             has_prefix;
      logic [NUM_W-1:0] number;
   } tln_entry_type;

   // Adds one to a BCD number; a number of all nines stays as it is.
   function automatic logic [NUM_W-1:0] bcd_increment(input logic [NUM_W-1:0] value);
      logic [NUM_W-1:0] result;
      logic             carry;
      logic             all_nines;
      result    = value;
      carry     = 1'b1;
      all_nines = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (value[4*i +: 4] != 4'd9) begin
            all_nines = 1'b0;
         end
         if (carry) begin
            if (value[4*i +: 4] >= 4'd9) begin
               result[4*i +: 4] = 4'd0;
            end else begin
               result[4*i +: 4] = value[4*i +: 4] + 4'd1;
               carry            = 1'b0;
            end
         end
      end
      if (all_nines) begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ hdl/tln_req_if.sv @@
// Input channel of the text line numberer: one text byte per transaction.
`default_nettype none

interface tln_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/tln_rsp_if.sv @@
// Result channel of the text line numberer: one emitted byte per transaction.
`default_nettype none

interface tln_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_in_run;

   modport source (output valid, output out_byte, output last_in_run, input ready);
   modport sink   (input valid, input out_byte, input last_in_run, output ready);
endinterface

`default_nettype wire

@@ hdl/text_line_numberer.sv @@
// Top level of the text line numberer: mode register, front, queue and back.
//
// The block numbers the lines of a text stream in the style of "cat -n" and "cat -b".
// Text bytes arrive one per transaction on req_if (valid, ready, in_byte). Every
// byte comes out again on rsp_if (valid, ready, out_byte, last_in_run) with
// last_in_run set. A byte that starts a numbered line is preceded by a prefix of
// seven transactions: the line number right-justified with spaces to six places,
// then a tab, all with last_in_run clear.
// csr_wr_en with csr_wr_data writes the mode: 1 numbers every line, 0 skips lines
// that are empty. Write it only while the block is idle.
// An accepted byte passes through a queue slot and then the output register.
// The output register emits one byte per cycle while rsp_if.ready is high;
// the two-entry queue takes one more byte while a prefix is being sent out,
// and further input waits until the prefixed byte leaves the queue.
// Reset is synchronous: the line number goes to 1, the next byte starts a line,
// the mode goes to number every line, and the queue and output register empty.
// When the receiver holds rsp_if.ready low, the output holds its transaction, the
// queue fills, and then req_if.ready falls until room opens up again.
// The counter stops at 999999 rather than wrapping.
`default_nettype none

module text_line_numberer (
   input  wire       clock,
   input  wire       reset,
   tln_req_if.sink   req_if,
   tln_rsp_if.source rsp_if,
   input  wire       csr_wr_en,
   input  wire       csr_wr_data
);
   import tln_pkg::*;

   logic          number_blank_lines_ff, number_blank_lines_in;
   logic          queue_full;
   logic          push;
   tln_entry_type push_entry;
   logic          pop;
   logic          head_valid;
   tln_entry_type head_entry;

   // The user must write the mode register only while the block is idle; the block itself does not enforce it.
   assign number_blank_lines_in = csr_wr_en ? csr_wr_data : number_blank_lines_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_blank_lines_ff <= 1'b1;
      end else begin
         number_blank_lines_ff <= number_blank_lines_in;
      end
   end

   // The front classifies each byte and advances the line counter as it accepts it.
   tln_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_if             (req_if),
      .number_blank_lines (number_blank_lines_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   // The queue carries each byte with its prefix decision and its line number.
   tln_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back sends the prefix and the byte out through its output register.
   tln_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

@@ hdl/tln_front.sv @@
// Front of the line numberer: accepts bytes, decides on prefixes, keeps the line counter.
`default_nettype none

module tln_front (
   input  wire                   clock,
   input  wire                   reset,
   tln_req_if.sink               req_if,
   input  wire                   number_blank_lines,
   input  wire                   queue_full,
   output logic                  push,
   output tln_pkg::tln_entry_type push_entry
);
   import tln_pkg::*;

   logic [NUM_W-1:0] line_number_ff, line_number_in;
   logic             at_line_start_ff, at_line_start_in;
   logic             is_newline;
   logic             has_prefix;
   logic             do_increment;

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   always_comb begin
      is_newline = (req_if.in_byte == NEWLINE_BYTE);
      // Without blank line numbering, a line that begins with a newline gets no number.
      has_prefix   = at_line_start_ff && (number_blank_lines || !is_newline);
      do_increment = number_blank_lines ? is_newline : has_prefix;

      line_number_in   = line_number_ff;
      at_line_start_in = at_line_start_ff;
      if (push) begin
         // In either mode the next byte starts a line exactly when this one is a newline.
         at_line_start_in = is_newline;
         if (do_increment) begin
            line_number_in = bcd_increment(line_number_ff);
         end
      end

      push_entry.in_byte    = req_if.in_byte;
      push_entry.has_prefix = has_prefix;
      push_entry.number     = line_number_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_number_ff   <= NUMBER_ONE;
         at_line_start_ff <= 1'b1;
      end else begin
         line_number_ff   <= line_number_in;
         at_line_start_ff <= at_line_start_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tln_queue.sv @@
// Short queue of classified bytes between the front and the back.
`default_nettype none

module tln_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  tln_pkg::tln_entry_type push_entry,
   output logic                   full,
   input  wire                    pop,
   output logic                   head_valid,
   output tln_pkg::tln_entry_type head_entry
);
   import tln_pkg::*;

   tln_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   always_comb begin
      full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];

      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tln_back.sv @@
// Back of the line numberer: expands queued bytes into prefix and passed bytes.
`default_nettype none

module tln_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    head_valid,
   input  tln_pkg::tln_entry_type head_entry,
   output logic                   pop,
   tln_rsp_if.source              rsp_if
);
   import tln_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              seen_ff, seen_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              emit;
   logic              is_last_step;
   logic [3:0]        nibble;
   logic              show_digit;

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.out_byte    = out_byte_ff;
   assign rsp_if.last_in_run = out_last_ff;

   always_comb begin
      out_free = !out_valid_ff || rsp_if.ready;
      emit     = head_valid && out_free;

      // Step s of the prefix shows the digit at position DIGITS-1-s, most significant first.
      nibble = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (step_ff == STEP_W'(DIGITS - 1 - i)) begin
            nibble = head_entry.number[4*i +: 4];
         end
      end
      // Leading zeros become spaces, but the units digit always shows.
      show_digit = seen_ff || (nibble != 4'd0) || (step_ff == STEP_W'(DIGITS - 1));

      is_last_step = !head_entry.has_prefix || (step_ff == STEP_W'(DIGITS + 1));
      pop          = emit && is_last_step;

      step_in      = step_ff;
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         if (is_last_step) begin
            out_byte_in = head_entry.in_byte;
            out_last_in = 1'b1;
            step_in     = '0;
            seen_in     = 1'b0;
         end else if (step_ff == STEP_W'(DIGITS)) begin
            out_byte_in = TAB_BYTE;
            out_last_in = 1'b0;
            step_in     = step_ff + STEP_W'(1);
         end else begin
            out_byte_in = show_digit ? {DIGIT_HIGH, nibble} : SPACE_BYTE;
            out_last_in = 1'b0;
            seen_in     = show_digit;
            step_in     = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench of the text line numberer: directed and random text with stalls.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tln_pkg::*;

   // Values of the mode register.
   localparam logic MODE_ALL_LINES      = 1'b1;
   localparam logic MODE_NONEMPTY_LINES = 1'b0;

   // The run is stopped as failed once this many cycles have gone by. The slowest
   // correct run, with every stall, stays well below it.
   localparam int CYCLE_LIMIT = 500_000;

   // Length of the long receiver hold-off of the back-pressure test, in cycles.
   localparam int LONG_HOLD_CYCLES = 150;

   // One emitted byte as the result channel carries it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_in_run;
   } line_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   tln_req_if req_chan();
   tln_rsp_if rsp_chan();

   text_line_numberer uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Our own copy of the numbering state. It starts at the values that reset gives.
   logic             numbering_all_lines = MODE_ALL_LINES;
   logic [NUM_W-1:0] line_number         = NUMBER_ONE;
   logic             awaiting_line_start = 1'b1;

   // Bytes the block still owes us, oldest first.
   line_byte_type emitted_bytes_due[$];
   line_byte_type oldest_due;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // When set, neither side inserts random gaps, so the block runs at full rate apart from a requested hold-off.
   bit steady_flow = 1'b0;

   // A test sets this to ask the receiver for one long hold-off.
   int rsp_hold_request = 0;
   int rsp_stall_left   = 0;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Advances the line number by one in BCD. A number of all nines is left alone,
   // since the block saturates instead of wrapping around.
   function automatic logic [NUM_W-1:0] bump_line_number(input logic [NUM_W-1:0] n);
      logic [NUM_W-1:0] r;
      int               pos;
      r   = n;
      pos = 0;
      if (n == {DIGITS{4'd9}}) begin
         return n;
      end
      while (r[4*pos +: 4] == 4'd9) begin
         r[4*pos +: 4] = 4'd0;
         pos++;
      end
      r[4*pos +: 4] = r[4*pos +: 4] + 4'd1;
      return r;
   endfunction

   function automatic void owe_byte(input logic [7:0] b, input logic last);
      line_byte_type item;
      item.out_byte    = b;
      item.last_in_run = last;
      emitted_bytes_due.push_back(item);
   endfunction

   // Queues the prefix for the current line number: the number right-justified
   // with spaces, then a tab. The units digit always shows, so at least one digit does.
   function automatic void owe_line_prefix();
      int top;
      top = 0;
      for (int pos = 0; pos < DIGITS; pos++) begin
         if (line_number[4*pos +: 4] != 4'd0) begin
            top = pos;
         end
      end
      for (int pos = DIGITS - 1; pos >= 0; pos--) begin
         if (pos > top) begin
            owe_byte(SPACE_BYTE, 1'b0);
         end else begin
            owe_byte({DIGIT_HIGH, line_number[4*pos +: 4]}, 1'b0);
         end
      end
      owe_byte(TAB_BYTE, 1'b0);
   endfunction

   // Works out what one accepted text byte makes the block emit and updates our
   // copy of the state. The two modes differ in when the number advances: in the
   // every-line mode on the newline, in the non-empty mode when the prefix goes out.
   function automatic void predict_emitted_bytes(input logic [7:0] b);
      logic is_newline;
      is_newline = (b == NEWLINE_BYTE);
      if (numbering_all_lines) begin
         if (awaiting_line_start) begin
            owe_line_prefix();
            awaiting_line_start = 1'b0;
         end
         owe_byte(b, 1'b1);
         if (is_newline) begin
            line_number         = bump_line_number(line_number);
            awaiting_line_start = 1'b1;
         end
      end else begin
         if (awaiting_line_start && !is_newline) begin
            owe_line_prefix();
            line_number         = bump_line_number(line_number);
            awaiting_line_start = 1'b0;
         end
         owe_byte(b, 1'b1);
         if (is_newline) begin
            awaiting_line_start = 1'b1;
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   // Every result transaction is compared with the oldest byte still owed. Only
   // the first ten mismatches are printed; the rest are just counted.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (emitted_bytes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected transaction: out_byte %02h last_in_run %0b",
                        rsp_chan.out_byte, rsp_chan.last_in_run);
            end
         end else begin
            oldest_due = emitted_bytes_due.pop_front();
            if (rsp_chan.out_byte !== oldest_due.out_byte ||
                rsp_chan.last_in_run !== oldest_due.last_in_run) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected out_byte %02h last_in_run %0b, got %02h %0b",
                           oldest_due.out_byte, oldest_due.last_in_run,
                           rsp_chan.out_byte, rsp_chan.last_in_run);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and flow control
   // ---------------------------------------------------------------------------

   // Gap length for either side: mostly none, sometimes a few cycles, now and
   // then a long one; none at all while the flow is steady.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // The receiver. A requested hold-off takes priority; otherwise ready is high
   // with random stalls, unless the flow is steady. One assignment per cycle.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            rsp_stall_left   = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (rsp_stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 5) == 0) begin
               rsp_stall_left = pick_gap() + 1;
            end
         end
      end
   end

   // Offers one text byte, after a random gap, and waits until the block takes
   // it. Valid stays high afterwards so that back-to-back bytes need no gap.
   task automatic send_text_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      predict_emitted_bytes(b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_text_byte(s[i]);
      end
   endtask

   // Stops offering input and waits until every owed byte has come out.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (emitted_bytes_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The mode register is only written while the block is idle.
   task automatic write_line_mode(input logic mode);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      numbering_all_lines = mode;
   endtask

   // Mostly printable characters, with the occasional arbitrary byte.
   function automatic logic [7:0] random_text_char();
      if ($urandom_range(0, 9) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(32, 126));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Right after reset the block numbers every line, empty ones included, from 1.
   task automatic test_reset_numbering();
      send_text("ab\n\nc\n");
   endtask

   // Extreme byte values: a zero byte is an ordinary byte, tab and space pass
   // through like text, and all ones must not be taken for anything special.
   task automatic test_byte_extremes();
      send_text_byte(8'h00);
      send_text_byte(8'hFF);
      send_text_byte(TAB_BYTE);
      send_text_byte(SPACE_BYTE);
      send_text_byte(NEWLINE_BYTE);
      send_text_byte(8'h00);
      send_text_byte(NEWLINE_BYTE);
   endtask

   // In the non-empty mode, lines that consist of just a newline get no number.
   task automatic test_skip_blank_lines();
      write_line_mode(MODE_NONEMPTY_LINES);
      send_text("\n\nx\n\ny\n");
   endtask

   // Both modes share the counter and the line-start flag. Switching after an
   // unnumbered blank line, and in the middle of a line, must keep them intact.
   task automatic test_mode_switch();
      send_text("\n");
      write_line_mode(MODE_ALL_LINES);
      send_text("\nab");
      write_line_mode(MODE_NONEMPTY_LINES);
      send_text("c\n\nd");
      write_line_mode(MODE_ALL_LINES);
      send_text("\n");
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // numbered lines, so the queue fills and the block stalls its input. Then the
   // sender pauses until every owed byte has come out.
   task automatic test_output_backpressure();
      steady_flow      = 1'b1;
      rsp_hold_request = LONG_HOLD_CYCLES;
      for (int i = 0; i < 6; i++) begin
         send_text_byte(random_text_char());
         send_text_byte(NEWLINE_BYTE);
      end
      drain_results();
      steady_flow = 1'b0;
   endtask

   // Walks the line number through the digit carries up to a three-digit number,
   // so the carry into the tens and the hundreds and the narrower pad widths show
   // up in a prefix. Newlines in the every-line mode advance the counter fastest.
   task automatic test_counter_carry_chain();
      write_line_mode(MODE_ALL_LINES);
      steady_flow = 1'b1;
      while (line_number < NUM_W'(24'h000103)) begin
         send_text_byte(NEWLINE_BYTE);
      end
      send_text("z\n");
      steady_flow = 1'b0;
   endtask

   // Random text in phases, each under a mode of its own. Most of it is lines of
   // text ended by a newline; some lines are empty, some are left open, and a
   // little is bursts of arbitrary bytes. Some phases run without any gaps.
   task automatic test_random_text();
      int sent;
      int len;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) begin
            write_line_mode(MODE_NONEMPTY_LINES);
         end else if (phase == 1) begin
            write_line_mode(MODE_ALL_LINES);
         end else begin
            write_line_mode(1'($urandom_range(0, 1)));
         end
         steady_flow = ($urandom_range(0, 3) == 0);
         sent        = 0;
         while (sent < 30) begin
            case ($urandom_range(0, 9))
               0: begin
                  len = $urandom_range(1, 4);
                  for (int i = 0; i < len; i++) begin
                     send_text_byte(8'($urandom_range(0, 255)));
                  end
                  sent += len;
               end
               1, 2: begin
                  send_text_byte(NEWLINE_BYTE);
                  sent++;
               end
               default: begin
                  len = $urandom_range(1, 10);
                  for (int i = 0; i < len; i++) begin
                     send_text_byte(random_text_char());
                  end
                  sent += len;
                  if ($urandom_range(0, 7) != 0) begin
                     send_text_byte(NEWLINE_BYTE);
                     sent++;
                  end
               end
            endcase
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_numbering();
      test_byte_extremes();
      test_skip_blank_lines();
      test_mode_switch();
      test_output_backpressure();
      test_counter_carry_chain();
      test_random_text();

      // Let the last bytes out, then give the block a few more cycles to show
      // any transaction that it should not send.
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && emitted_bytes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
